// ----- hw/rtl/ftt_pkg.sv -----
`default_nettype none

package ftt_pkg;

    // Command carried by each input item
    typedef enum logic [1:0] {
        FUNC_TICK          = 2'd0,
        FUNC_START_KEEPING = 2'd1,
        FUNC_STOP_KEEPING  = 2'd2,
        FUNC_START_TIMEOUT = 2'd3
    } func_t;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PERIOD_STEP        = 2'd0,
        CFG_STRETCH_EVERY      = 2'd1,
        CFG_PERIODS_PER_SECOND = 2'd2,
        CFG_UNUSED             = 2'd3
    } cfg_index_t;

    localparam int STEP_BITS  = 16;
    localparam int INDEX_BITS = 5;
    localparam int SEC_BITS   = 16;
    localparam int DELAY_BITS = 9;

    localparam logic [STEP_BITS-1:0]  PERIOD_STEP_RESET        = 16'd819;
    localparam logic [INDEX_BITS-1:0] STRETCH_EVERY_RESET      = 5'd5;
    localparam logic [INDEX_BITS-1:0] PERIODS_PER_SECOND_RESET = 5'd20;

    typedef struct packed {
        logic [STEP_BITS-1:0]  period_step;
        logic [INDEX_BITS-1:0] stretch_every;
        logic [INDEX_BITS-1:0] periods_per_second;
    } cfg_t;

    typedef struct packed {
        logic [SEC_BITS-1:0] seconds;
        logic [15:0]         ticks_in_second;
        logic                period_pulse;
        logic                second_pulse;
        logic                timeout_expired;
        logic                counter_running;
    } result_t;

    // Tick delay for each timeout code; unlisted codes fall back to the shortest
    function automatic logic [DELAY_BITS-1:0] timeout_delay(input logic [2:0] code);
        logic [DELAY_BITS-1:0] d;
        unique case (code)
            3'd1:    d = 9'd10;
            3'd2:    d = 9'd20;
            3'd3:    d = 9'd38;
            3'd4:    d = 9'd76;
            3'd5:    d = 9'd150;
            3'd6:    d = 9'd299;
            default: d = 9'd10;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ftt_cfg_regs.sv -----
`default_nettype none

module ftt_cfg_regs (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ftt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [ftt_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output ftt_pkg::cfg_t                             cfg
);
    import ftt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PERIOD_STEP:        cfg_next.period_step = cfg_data;
                CFG_STRETCH_EVERY:      cfg_next.stretch_every = cfg_data[INDEX_BITS-1:0];
                CFG_PERIODS_PER_SECOND: cfg_next.periods_per_second = cfg_data[INDEX_BITS-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.period_step        <= PERIOD_STEP_RESET;
            cfg_reg.stretch_every      <= STRETCH_EVERY_RESET;
            cfg_reg.periods_per_second <= PERIODS_PER_SECOND_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ftt_core.sv -----
`default_nettype none

module ftt_core #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step_en,
    input  wire logic [1:0]       func,
    input  wire logic [2:0]       timeout_code,
    input  wire ftt_pkg::cfg_t    cfg,
    output ftt_pkg::result_t      result
);
    import ftt_pkg::*;

    localparam int CB = COUNTER_BITS;

    logic [CB-1:0]         tick_reg, tick_next;
    logic [CB-1:0]         pcmp_reg, pcmp_next;
    logic [CB-1:0]         tcmp_reg, tcmp_next;
    logic [CB-1:0]         mark_reg, mark_next;
    logic [INDEX_BITS-1:0] pidx_reg, pidx_next;
    logic [INDEX_BITS-1:0] sidx_reg, sidx_next;
    logic [SEC_BITS-1:0]   secs_reg, secs_next;
    logic                  keep_reg, keep_next;
    logic                  armed_reg, armed_next;

    logic [CB-1:0]          tick_inc;
    logic [INDEX_BITS-1:0]  pidx_inc;
    logic [INDEX_BITS-1:0]  sidx_inc;
    logic                   stretch_hit;
    logic [STEP_BITS:0]     step_full;
    logic [CB+STEP_BITS:0]  pcmp_sum;
    logic [CB+STEP_BITS-1:0] step_ext;
    logic [CB+DELAY_BITS-1:0] delay_ext;
    logic [CB-1:0]          diff;
    logic [CB+15:0]         diff_ext;
    logic                   per_hit;
    logic                   sec_hit;
    logic                   tmo_hit;

    always_comb begin
        tick_inc    = tick_reg + {{(CB-1){1'b0}}, 1'b1};
        pidx_inc    = pidx_reg + 5'd1;
        sidx_inc    = sidx_reg + 5'd1;
        stretch_hit = (sidx_inc == cfg.stretch_every);
        step_full   = {1'b0, cfg.period_step} + {{STEP_BITS{1'b0}}, stretch_hit};
        pcmp_sum    = {{(STEP_BITS+1){1'b0}}, pcmp_reg} + {{CB{1'b0}}, step_full};
        step_ext    = {{CB{1'b0}}, cfg.period_step};
        delay_ext   = {{CB{1'b0}}, timeout_delay(timeout_code)};

        tick_next  = tick_reg;
        pcmp_next  = pcmp_reg;
        tcmp_next  = tcmp_reg;
        mark_next  = mark_reg;
        pidx_next  = pidx_reg;
        sidx_next  = sidx_reg;
        secs_next  = secs_reg;
        keep_next  = keep_reg;
        armed_next = armed_reg;
        per_hit    = 1'b0;
        sec_hit    = 1'b0;
        tmo_hit    = 1'b0;

        unique case (func_t'(func))
            FUNC_TICK: begin
                if (keep_reg || armed_reg) begin
                    tick_next = tick_inc;
                    per_hit   = keep_reg && (tick_inc == pcmp_reg);
                    tmo_hit   = armed_reg && (tick_inc == tcmp_reg);
                    if (per_hit) begin
                        pcmp_next = pcmp_sum[CB-1:0];
                        pidx_next = pidx_inc;
                        sidx_next = stretch_hit ? '0 : sidx_inc;
                        sec_hit   = (pidx_inc == cfg.periods_per_second);
                        // Second boundary: latch the mark, restart both indexes and count the second
                        if (sec_hit) begin
                            mark_next = tick_inc;
                            pidx_next = '0;
                            sidx_next = '0;
                            secs_next = secs_reg + 16'd1;
                        end
                    end
                    if (tmo_hit) begin
                        armed_next = 1'b0;
                    end
                end
            end
            FUNC_START_KEEPING: begin
                tick_next = '0;
                secs_next = '0;
                mark_next = '0;
                pcmp_next = step_ext[CB-1:0];
                keep_next = 1'b1;
            end
            FUNC_STOP_KEEPING: begin
                keep_next = 1'b0;
            end
            FUNC_START_TIMEOUT: begin
                tcmp_next  = tick_reg + delay_ext[CB-1:0];
                armed_next = 1'b1;
            end
            default: begin
                tick_next = tick_reg;
            end
        endcase

        diff     = tick_next - mark_next;
        diff_ext = {16'b0, diff};

        result.seconds         = secs_next;
        result.ticks_in_second = diff_ext[15:0];
        result.period_pulse    = per_hit;
        result.second_pulse    = sec_hit;
        result.timeout_expired = tmo_hit;
        result.counter_running = keep_next || armed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg  <= '0;
            pcmp_reg  <= '0;
            tcmp_reg  <= '0;
            mark_reg  <= '0;
            pidx_reg  <= '0;
            sidx_reg  <= '0;
            secs_reg  <= '0;
            keep_reg  <= 1'b0;
            armed_reg <= 1'b0;
        end else if (step_en) begin
            tick_reg  <= tick_next;
            pcmp_reg  <= pcmp_next;
            tcmp_reg  <= tcmp_next;
            mark_reg  <= mark_next;
            pidx_reg  <= pidx_next;
            sidx_reg  <= sidx_next;
            secs_reg  <= secs_next;
            keep_reg  <= keep_next;
            armed_reg <= armed_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fractional_tick_timekeeper_timeout_unit.sv -----
`default_nettype none
// Channel  | Direction | Handshake             | Payload
// s_       | in        | s_valid / s_ready     | s_func, s_timeout_code
// m_       | out       | m_valid / m_ready     | m_seconds, m_ticks_in_second, pulses, running
// cfg_     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle while m_ready is high; an accepted item sits in the input register until
// the result register is free, then updates the state and loads it in one pass; m_valid rises.
// Timer state lives in one register bank that advances as the item leaves the input register.
// aresetn is synchronous, active low; it clears all timer state and loads default settings.
// A stalled m_ready holds the result register and, once the input register is full, s_ready.

module fractional_tick_timekeeper_timeout_unit #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [1:0]                           s_func,
    input  wire logic [2:0]                           s_timeout_code,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [15:0]                               m_seconds,
    output logic [15:0]                               m_ticks_in_second,
    output logic                                      m_period_pulse,
    output logic                                      m_second_pulse,
    output logic                                      m_timeout_expired,
    output logic                                      m_counter_running,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ftt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [ftt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import ftt_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t out_reg;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [1:0] in_func_reg;
    logic [2:0] in_code_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       advance;
    logic       accept;

    ftt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ftt_core #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .func         (in_func_reg),
        .timeout_code (in_code_reg),
        .cfg          (cfg),
        .result       (result)
    );

    // Move the held item into the result register whenever that register frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_func_reg <= s_func;
            in_code_reg <= s_timeout_code;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_seconds         = out_reg.seconds;
    assign m_ticks_in_second = out_reg.ticks_in_second;
    assign m_period_pulse    = out_reg.period_pulse;
    assign m_second_pulse    = out_reg.second_pulse;
    assign m_timeout_expired = out_reg.timeout_expired;
    assign m_counter_running = out_reg.counter_running;

endmodule

`default_nettype wire
